// ===== rtl/core/usplit_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package usplit_pkg;

  // parser states, one-hot
  typedef enum logic [8:0] {
    ST_SCHEME = 9'b000000001,
    ST_HEX1   = 9'b000000010,
    ST_HEX2   = 9'b000000100,
    ST_COLON  = 9'b000001000,
    ST_SLASH1 = 9'b000010000,
    ST_AUTH   = 9'b000100000,
    ST_PATH   = 9'b001000000,
    ST_QUERY  = 9'b010000000,
    ST_FRAG   = 9'b100000000
  } pstate_t;

  typedef enum logic [2:0] {
    COMP_SCHEME = 3'd0,
    COMP_AUTH   = 3'd1,
    COMP_PATH   = 3'd2,
    COMP_QUERY  = 3'd3,
    COMP_FRAG   = 3'd4
  } comp_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_SCHEME = 3'd1,
    STAT_BAD_HEX    = 3'd2,
    STAT_NO_SCHEME  = 3'd3,
    STAT_TRUNC_ESC  = 3'd4
  } status_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  typedef struct packed {
    logic [7:0] byte_out;
    logic [2:0] component;
    logic       has_byte;
    logic       uri_done;
    logic [2:0] status;
  } res_t;

  // all results caused by one item
  typedef struct packed {
    res_t [3:0] res;
    logic [1:0] last;
  } bundle_t;

  typedef struct packed {
    pstate_t    pstate;
    pstate_t    rstate;
    logic [3:0] high_nibble;
    logic [1:0] held_count;
    logic       path_checking;
    logic       discarding;
  } ctl_t;

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_scheme_char(input logic [7:0] c);
    return is_letter(c) || (c inside {[8'h30:8'h39], CH_PLUS, CH_MINUS, CH_DOT});
  endfunction

  // bit 4 flags a valid hex digit, bits 3:0 its value
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b1, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  function automatic res_t mk_byte(input logic [7:0] b, input comp_t comp);
    res_t r;
    r.byte_out  = b;
    r.component = comp;
    r.has_byte  = 1'b1;
    r.uri_done  = 1'b0;
    r.status    = STAT_OK;
    return r;
  endfunction

  function automatic res_t mk_status(input status_t st);
    res_t r;
    r.byte_out  = 8'd0;
    r.component = COMP_SCHEME;
    r.has_byte  = 1'b0;
    r.uri_done  = 1'b1;
    r.status    = st;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/usplit_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usplit_step (
  input  var usplit_pkg::ctl_t    cur_i,
  input  wire logic [7:0]         held0_i,
  input  wire logic [7:0]         held1_i,
  input  wire logic [7:0]         byte_i,
  input  wire logic               end_i,
  output usplit_pkg::ctl_t        nxt_o,
  output logic [7:0]              held0_o,
  output logic [7:0]              held1_o,
  output usplit_pkg::bundle_t     bundle_o,
  output logic                    has_res_o
);

  usplit_pkg::ctl_t    nx;
  usplit_pkg::res_t [3:0] res;
  logic [2:0]          n;
  logic [7:0]          h0, h1, pb, dec, up;
  logic [4:0]          hv;
  logic                err;
  usplit_pkg::status_t err_code;
  usplit_pkg::status_t end_code;
  logic                begin_req, flush_req;
  logic [1:0]          p_en;
  logic [7:0]          p_b0, p_b1;
  // path character outcome for the current byte
  logic                pc_esc, pc_q, pc_f;

  always_comb begin
    nx        = cur_i;
    h0        = held0_i;
    h1        = held1_i;
    res       = '0;
    n         = 3'd0;
    err       = 1'b0;
    err_code  = usplit_pkg::STAT_OK;
    end_code  = usplit_pkg::STAT_OK;
    begin_req = 1'b0;
    flush_req = 1'b0;
    p_en      = 2'b00;
    p_b0      = byte_i;
    p_b1      = byte_i;
    pb        = 8'd0;
    up        = 8'd0;
    hv        = usplit_pkg::hex_value(byte_i);
    dec       = {cur_i.high_nibble, hv[3:0]};
    pc_esc    = (byte_i == usplit_pkg::CH_PCT);
    pc_q      = (byte_i == usplit_pkg::CH_QMARK);
    pc_f      = (byte_i == usplit_pkg::CH_HASH);

    if (cur_i.discarding) begin
      if (end_i) begin
        nx.discarding    = 1'b0;
        nx.pstate        = usplit_pkg::ST_SCHEME;
        nx.rstate        = usplit_pkg::ST_SCHEME;
        nx.high_nibble   = 4'd0;
        nx.held_count    = 2'd0;
        nx.path_checking = 1'b0;
      end
    end else begin
      case (cur_i.pstate)
        usplit_pkg::ST_SCHEME: begin
          if (pc_esc) begin
            nx.rstate = usplit_pkg::ST_SCHEME;
            nx.pstate = usplit_pkg::ST_HEX1;
          end else if (byte_i == usplit_pkg::CH_COLON) begin
            nx.pstate = usplit_pkg::ST_COLON;
          end else if (usplit_pkg::is_scheme_char(byte_i)) begin
            res[n[1:0]] = usplit_pkg::mk_byte(byte_i, usplit_pkg::COMP_SCHEME);
            n = n + 3'd1;
          end else begin
            err      = 1'b1;
            err_code = usplit_pkg::STAT_BAD_SCHEME;
          end
        end
        usplit_pkg::ST_HEX1: begin
          if (!hv[4]) begin
            err      = 1'b1;
            err_code = usplit_pkg::STAT_BAD_HEX;
          end else begin
            nx.high_nibble = hv[3:0];
            nx.pstate      = usplit_pkg::ST_HEX2;
          end
        end
        usplit_pkg::ST_HEX2: begin
          if (!hv[4]) begin
            err      = 1'b1;
            err_code = usplit_pkg::STAT_BAD_HEX;
          end else begin
            nx.pstate = cur_i.rstate;
            case (cur_i.rstate)
              usplit_pkg::ST_AUTH: begin
                res[n[1:0]] = usplit_pkg::mk_byte(dec, usplit_pkg::COMP_AUTH);
                n = n + 3'd1;
              end
              usplit_pkg::ST_PATH: begin
                p_en[0] = 1'b1;
                p_b0    = dec;
              end
              usplit_pkg::ST_QUERY: begin
                res[n[1:0]] = usplit_pkg::mk_byte(dec, usplit_pkg::COMP_QUERY);
                n = n + 3'd1;
              end
              usplit_pkg::ST_FRAG: begin
                res[n[1:0]] = usplit_pkg::mk_byte(dec, usplit_pkg::COMP_FRAG);
                n = n + 3'd1;
              end
              default: begin
                res[n[1:0]] = usplit_pkg::mk_byte(dec, usplit_pkg::COMP_SCHEME);
                n = n + 3'd1;
              end
            endcase
          end
        end
        usplit_pkg::ST_COLON: begin
          if (byte_i == usplit_pkg::CH_SLASH) begin
            nx.pstate = usplit_pkg::ST_SLASH1;
          end else if (pc_q) begin
            nx.pstate = usplit_pkg::ST_QUERY;
          end else if (pc_f) begin
            nx.pstate = usplit_pkg::ST_FRAG;
          end else begin
            // anything else opens a path
            begin_req = 1'b1;
            nx.pstate = usplit_pkg::ST_PATH;
            if (pc_esc) begin
              nx.rstate = usplit_pkg::ST_PATH;
              nx.pstate = usplit_pkg::ST_HEX1;
            end else begin
              p_en[0] = 1'b1;
            end
          end
        end
        usplit_pkg::ST_SLASH1: begin
          if (byte_i == usplit_pkg::CH_SLASH) begin
            nx.pstate = usplit_pkg::ST_AUTH;
          end else begin
            // single slash: path that starts with '/'
            begin_req = 1'b1;
            p_en[0]   = 1'b1;
            p_b0      = usplit_pkg::CH_SLASH;
            nx.pstate = usplit_pkg::ST_PATH;
            if (pc_esc) begin
              nx.rstate = usplit_pkg::ST_PATH;
              nx.pstate = usplit_pkg::ST_HEX1;
            end else if (pc_q) begin
              flush_req = 1'b1;
              nx.pstate = usplit_pkg::ST_QUERY;
            end else if (pc_f) begin
              flush_req = 1'b1;
              nx.pstate = usplit_pkg::ST_FRAG;
            end else begin
              p_en[1] = 1'b1;
            end
          end
        end
        usplit_pkg::ST_AUTH: begin
          if (pc_esc) begin
            nx.rstate = usplit_pkg::ST_AUTH;
            nx.pstate = usplit_pkg::ST_HEX1;
          end else if (byte_i == usplit_pkg::CH_SLASH) begin
            begin_req = 1'b1;
            p_en[0]   = 1'b1;
            nx.pstate = usplit_pkg::ST_PATH;
          end else if (pc_q) begin
            nx.pstate = usplit_pkg::ST_QUERY;
          end else if (pc_f) begin
            nx.pstate = usplit_pkg::ST_FRAG;
          end else begin
            res[n[1:0]] = usplit_pkg::mk_byte(byte_i, usplit_pkg::COMP_AUTH);
            n = n + 3'd1;
          end
        end
        usplit_pkg::ST_PATH: begin
          if (pc_esc) begin
            nx.rstate = usplit_pkg::ST_PATH;
            nx.pstate = usplit_pkg::ST_HEX1;
          end else if (pc_q) begin
            flush_req = 1'b1;
            nx.pstate = usplit_pkg::ST_QUERY;
          end else if (pc_f) begin
            flush_req = 1'b1;
            nx.pstate = usplit_pkg::ST_FRAG;
          end else begin
            p_en[0] = 1'b1;
          end
        end
        usplit_pkg::ST_QUERY: begin
          if (pc_esc) begin
            nx.rstate = usplit_pkg::ST_QUERY;
            nx.pstate = usplit_pkg::ST_HEX1;
          end else if (pc_f) begin
            nx.pstate = usplit_pkg::ST_FRAG;
          end else begin
            res[n[1:0]] = usplit_pkg::mk_byte(byte_i, usplit_pkg::COMP_QUERY);
            n = n + 3'd1;
          end
        end
        default: begin
          if (pc_esc) begin
            nx.rstate = usplit_pkg::ST_FRAG;
            nx.pstate = usplit_pkg::ST_HEX1;
          end else begin
            res[n[1:0]] = usplit_pkg::mk_byte(byte_i, usplit_pkg::COMP_FRAG);
            n = n + 3'd1;
          end
        end
      endcase

      if (begin_req) begin
        nx.path_checking = 1'b1;
        nx.held_count    = 2'd0;
      end

      // path bytes: hold the first two until a drive letter is ruled in or out
      for (int i = 0; i < 2; i++) begin
        if (p_en[i]) begin
          pb = (i == 0) ? p_b0 : p_b1;
          if (!nx.path_checking) begin
            res[n[1:0]] = usplit_pkg::mk_byte(pb, usplit_pkg::COMP_PATH);
            n = n + 3'd1;
          end else if (nx.held_count == 2'd0) begin
            h0 = pb;
            nx.held_count = 2'd1;
          end else if (nx.held_count == 2'd1) begin
            h1 = pb;
            nx.held_count = 2'd2;
          end else begin
            if (h0 == usplit_pkg::CH_SLASH && usplit_pkg::is_letter(h1) &&
                pb == usplit_pkg::CH_COLON) begin
              up = (h1 inside {[8'h61:8'h7a]}) ? (h1 - 8'h20) : h1;
              res[n[1:0]] = usplit_pkg::mk_byte(up, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
              res[n[1:0]] = usplit_pkg::mk_byte(pb, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
            end else begin
              res[n[1:0]] = usplit_pkg::mk_byte(h0, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
              res[n[1:0]] = usplit_pkg::mk_byte(h1, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
              res[n[1:0]] = usplit_pkg::mk_byte(pb, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
            end
            nx.path_checking = 1'b0;
            nx.held_count    = 2'd0;
          end
        end
      end

      if (err) begin
        res[n[1:0]] = usplit_pkg::mk_status(err_code);
        n = n + 3'd1;
        nx.pstate        = usplit_pkg::ST_SCHEME;
        nx.rstate        = usplit_pkg::ST_SCHEME;
        nx.high_nibble   = 4'd0;
        nx.held_count    = 2'd0;
        nx.path_checking = 1'b0;
        nx.discarding    = !end_i;
      end else begin
        if (flush_req || end_i) begin
          if (nx.path_checking && !(end_i && (nx.pstate == usplit_pkg::ST_SCHEME ||
              nx.pstate == usplit_pkg::ST_HEX1 || nx.pstate == usplit_pkg::ST_HEX2))) begin
            if (nx.held_count != 2'd0) begin
              res[n[1:0]] = usplit_pkg::mk_byte(h0, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
            end
            if (nx.held_count == 2'd2) begin
              res[n[1:0]] = usplit_pkg::mk_byte(h1, usplit_pkg::COMP_PATH);
              n = n + 3'd1;
            end
            nx.path_checking = 1'b0;
            nx.held_count    = 2'd0;
          end
        end
        if (end_i) begin
          if (nx.pstate == usplit_pkg::ST_SCHEME) begin
            end_code = usplit_pkg::STAT_NO_SCHEME;
          end else if (nx.pstate == usplit_pkg::ST_HEX1 || nx.pstate == usplit_pkg::ST_HEX2) begin
            end_code = usplit_pkg::STAT_TRUNC_ESC;
          end
          res[n[1:0]] = usplit_pkg::mk_status(end_code);
          n = n + 3'd1;
          nx.pstate        = usplit_pkg::ST_SCHEME;
          nx.rstate        = usplit_pkg::ST_SCHEME;
          nx.high_nibble   = 4'd0;
          nx.held_count    = 2'd0;
          nx.path_checking = 1'b0;
        end
      end
    end
  end

  always_comb begin
    nxt_o         = nx;
    held0_o       = h0;
    held1_o       = h1;
    bundle_o.res  = res;
    bundle_o.last = n[1:0] - 2'd1;
    has_res_o     = (n != 3'd0);
  end

endmodule

`default_nettype wire

// ===== rtl/core/usplit_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module usplit_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en_i,
  input  var usplit_pkg::bundle_t  wr_bundle_i,
  output logic                     ready_o,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output usplit_pkg::res_t         out_res_o
);

  usplit_pkg::bundle_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take, pop;

  assign ready_o   = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res_o = q_r[rd_ptr_r].res[idx_r];
  assign take      = out_valid && !out_stall;
  assign pop       = take && (idx_r == q_r[rd_ptr_r].last);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en_i;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, wr_en_i} - {1'b0, pop};
    idx_nxt    = idx_r;
    if (pop) begin
      idx_nxt = 2'd0;
    end else if (take) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      q_r[wr_ptr_r] <= wr_bundle_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/uri_component_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// uri splitter with percent decoding
// input channel: one raw uri character per item (in_byte_in), in_end_of_uri
//   set on the last character of a uri
// result channel: one result per item; byte results carry a decoded byte and
//   its component (scheme, authority, path, query, fragment), the last result
//   of every uri is a status result with out_uri_done set
// one input item causes zero to four results
// an item's first result passes the input register and a queue entry before
//   it is offered; one input item per cycle while out_stall is low and each
//   item gives at most one result; an item with several results holds the
//   output until all are taken, and the two-entry queue keeps the input side
//   moving meanwhile; when out_stall is high the result on offer holds; once
//   both queue entries are full the input register fills and in_stall rises
// reset (rst_n low, synchronous) returns the parser to the scheme state and
//   empties the input register and the result queue

module uri_component_splitter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_in,
  input  wire logic       in_end_of_uri,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte_out,
  output logic [2:0]      out_component,
  output logic            out_has_byte,
  output logic            out_uri_done,
  output logic [2:0]      out_status
);

  // input register
  logic       item_v_r, item_v_nxt;
  logic [7:0] byte_r;
  logic       end_r;

  // parser state; held path bytes have no reset, they are only read once written
  usplit_pkg::ctl_t ctl_r, ctl_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;

  usplit_pkg::bundle_t bundle;
  usplit_pkg::res_t    res;
  logic                has_res;
  logic                q_ready;
  logic                move;
  logic                in_take;

  // item leaves the input register once the queue has a free entry
  assign move     = item_v_r && q_ready;
  assign in_stall = item_v_r && !q_ready;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    item_v_nxt = item_v_r;
    if (in_take) begin
      item_v_nxt = 1'b1;
    end else if (move) begin
      item_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r             <= 1'b0;
      ctl_r.pstate         <= usplit_pkg::ST_SCHEME;
      ctl_r.rstate         <= usplit_pkg::ST_SCHEME;
      ctl_r.high_nibble    <= 4'd0;
      ctl_r.held_count     <= 2'd0;
      ctl_r.path_checking  <= 1'b0;
      ctl_r.discarding     <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      if (move) begin
        ctl_r <= ctl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte_in;
      end_r  <= in_end_of_uri;
    end
    if (move) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

  // per-character parse, decode and drive-letter handling
  usplit_step u_step (
    .cur_i     (ctl_r),
    .held0_i   (held0_r),
    .held1_i   (held1_r),
    .byte_i    (byte_r),
    .end_i     (end_r),
    .nxt_o     (ctl_nxt),
    .held0_o   (held0_nxt),
    .held1_o   (held1_nxt),
    .bundle_o  (bundle),
    .has_res_o (has_res)
  );

  // result queue, serialises each item's results onto the output
  usplit_outq u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en_i     (move && has_res),
    .wr_bundle_i (bundle),
    .ready_o     (q_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res_o   (res)
  );

  assign out_byte_out  = res.byte_out;
  assign out_component = res.component;
  assign out_has_byte  = res.has_byte;
  assign out_uri_done  = res.uri_done;
  assign out_status    = res.status;

endmodule

`default_nettype wire

// ===== test/uri_component_splitter_test.sv =====
`timescale 1ns / 1ps

module uri_component_splitter_test;
  import usplit_pkg::*;

  // character bounds used by the predictor and the stimulus
  localparam logic [7:0] UC_A  = 8'h41;
  localparam logic [7:0] UC_F  = 8'h46;
  localparam logic [7:0] UC_Z  = 8'h5a;
  localparam logic [7:0] LC_A  = 8'h61;
  localparam logic [7:0] LC_F  = 8'h66;
  localparam logic [7:0] LC_Z  = 8'h7a;
  localparam logic [7:0] DIG_0 = 8'h30;
  localparam logic [7:0] DIG_9 = 8'h39;

  // generous: every item at four results, each result behind a long stall
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 350;
  localparam int REPORT_LIMIT = 10;

  // splitter behaviour model plus the queue of results it still owes
  class splitter_scoreboard;
    res_t       owed_q[$];
    pstate_t    state;
    pstate_t    resume;
    logic [3:0] hi_nib;
    logic [7:0] held [2];
    int         held_n;
    bit         checking;
    bit         dropping;
    int         failures;
    int         checked;
    int         error_statuses;

    function new();
      restart();
      held[0] = 8'd0;
      held[1] = 8'd0;
      dropping = 1'b0;
      failures = 0;
      checked = 0;
      error_statuses = 0;
    endfunction

    function void restart();
      state = ST_SCHEME;
      resume = ST_SCHEME;
      hi_nib = 4'd0;
      held_n = 0;
      checking = 1'b0;
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= UC_A && c <= UC_Z) || (c >= LC_A && c <= LC_Z);
    endfunction

    function bit scheme_ok(logic [7:0] c);
      return is_alpha(c) || (c >= DIG_0 && c <= DIG_9) ||
             c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    // -1 when not a hex digit
    function int hex_val(logic [7:0] c);
      if (c >= DIG_0 && c <= DIG_9) return int'(c - DIG_0);
      if (c >= LC_A && c <= LC_F) return int'(c - LC_A) + 10;
      if (c >= UC_A && c <= UC_F) return int'(c - UC_A) + 10;
      return -1;
    endfunction

    function void owe_byte(logic [7:0] b, comp_t comp);
      res_t r;
      r.byte_out = b;
      r.component = comp;
      r.has_byte = 1'b1;
      r.uri_done = 1'b0;
      r.status = STAT_OK;
      owed_q.push_back(r);
    endfunction

    function void owe_status(status_t st);
      res_t r;
      r.byte_out = 8'd0;
      r.component = COMP_SCHEME;
      r.has_byte = 1'b0;
      r.uri_done = 1'b1;
      r.status = st;
      owed_q.push_back(r);
    endfunction

    function void open_path();
      checking = 1'b1;
      held_n = 0;
    endfunction

    // the first two path bytes wait until a drive letter is ruled in or out
    function void hold_path(logic [7:0] b);
      logic [7:0] d;
      if (!checking) begin
        owe_byte(b, COMP_PATH);
        return;
      end
      if (held_n < 2) begin
        held[held_n] = b;
        held_n++;
        return;
      end
      if (held[0] == CH_SLASH && is_alpha(held[1]) && b == CH_COLON) begin
        d = held[1];
        if (d >= LC_A && d <= LC_Z) d = d - 8'h20;
        owe_byte(d, COMP_PATH);
        owe_byte(b, COMP_PATH);
      end else begin
        owe_byte(held[0], COMP_PATH);
        owe_byte(held[1], COMP_PATH);
        owe_byte(b, COMP_PATH);
      end
      checking = 1'b0;
      held_n = 0;
    endfunction

    function void flush_held();
      if (checking) begin
        for (int i = 0; i < held_n && i < 2; i++) owe_byte(held[i], COMP_PATH);
      end
      checking = 1'b0;
      held_n = 0;
    endfunction

    function void path_byte(logic [7:0] c);
      state = ST_PATH;
      if (c == CH_PCT) begin
        resume = ST_PATH;
        state = ST_HEX1;
      end else if (c == CH_QMARK) begin
        flush_held();
        state = ST_QUERY;
      end else if (c == CH_HASH) begin
        flush_held();
        state = ST_FRAG;
      end else begin
        hold_path(c);
      end
    endfunction

    function void deliver_decoded(logic [7:0] b);
      case (resume)
        ST_AUTH:  owe_byte(b, COMP_AUTH);
        ST_PATH:  hold_path(b);
        ST_QUERY: owe_byte(b, COMP_QUERY);
        ST_FRAG:  owe_byte(b, COMP_FRAG);
        default:  owe_byte(b, COMP_SCHEME);
      endcase
      state = resume;
    endfunction

    // one accepted input item: work out every result it causes
    function void note_item(logic [7:0] c, logic last);
      int      h;
      bit      failed;
      status_t err;
      status_t st;
      failed = 1'b0;
      err = STAT_OK;
      st = STAT_OK;
      if (dropping) begin
        if (last) begin
          dropping = 1'b0;
          restart();
        end
        return;
      end
      case (state)
        ST_SCHEME: begin
          if (c == CH_PCT) begin
            resume = ST_SCHEME;
            state = ST_HEX1;
          end else if (c == CH_COLON) begin
            state = ST_COLON;
          end else if (scheme_ok(c)) begin
            owe_byte(c, COMP_SCHEME);
          end else begin
            failed = 1'b1;
            err = STAT_BAD_SCHEME;
          end
        end
        ST_HEX1: begin
          h = hex_val(c);
          if (h < 0) begin
            failed = 1'b1;
            err = STAT_BAD_HEX;
          end else begin
            hi_nib = 4'(h);
            state = ST_HEX2;
          end
        end
        ST_HEX2: begin
          h = hex_val(c);
          if (h < 0) begin
            failed = 1'b1;
            err = STAT_BAD_HEX;
          end else begin
            deliver_decoded({hi_nib, 4'(h)});
          end
        end
        ST_COLON: begin
          if (c == CH_SLASH) state = ST_SLASH1;
          else if (c == CH_QMARK) state = ST_QUERY;
          else if (c == CH_HASH) state = ST_FRAG;
          else begin
            open_path();
            path_byte(c);
          end
        end
        ST_SLASH1: begin
          if (c == CH_SLASH) state = ST_AUTH;
          else begin
            open_path();
            hold_path(CH_SLASH);
            path_byte(c);
          end
        end
        ST_AUTH: begin
          if (c == CH_PCT) begin
            resume = ST_AUTH;
            state = ST_HEX1;
          end else if (c == CH_SLASH) begin
            open_path();
            hold_path(CH_SLASH);
            state = ST_PATH;
          end else if (c == CH_QMARK) state = ST_QUERY;
          else if (c == CH_HASH) state = ST_FRAG;
          else owe_byte(c, COMP_AUTH);
        end
        ST_PATH: path_byte(c);
        ST_QUERY: begin
          if (c == CH_PCT) begin
            resume = ST_QUERY;
            state = ST_HEX1;
          end else if (c == CH_HASH) state = ST_FRAG;
          else owe_byte(c, COMP_QUERY);
        end
        default: begin
          if (c == CH_PCT) begin
            resume = ST_FRAG;
            state = ST_HEX1;
          end else owe_byte(c, COMP_FRAG);
        end
      endcase
      if (failed) begin
        owe_status(err);
        restart();
        dropping = !last;
        return;
      end
      if (last) begin
        if (state == ST_SCHEME) st = STAT_NO_SCHEME;
        else if (state == ST_HEX1 || state == ST_HEX2) st = STAT_TRUNC_ESC;
        else flush_held();
        owe_status(st);
        restart();
      end
    endfunction

    // one accepted result against the oldest owed one
    function void check_result(res_t got);
      res_t want;
      bit   bad;
      checked++;
      if (got.uri_done === 1'b1 && got.status != STAT_OK) error_statuses++;
      if (owed_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("result %0d arrived with none owed: byte %02h comp %0d has %0b done %0b st %0d",
                   checked, got.byte_out, got.component, got.has_byte, got.uri_done,
                   got.status);
        return;
      end
      want = owed_q.pop_front();
      bad = (got.byte_out !== want.byte_out) || (got.component !== want.component) ||
            (got.has_byte !== want.has_byte) || (got.uri_done !== want.uri_done) ||
            (got.status !== want.status);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("result %0d mismatch: want byte %02h comp %0d has %0b done %0b st %0d",
                   checked, want.byte_out, want.component, want.has_byte, want.uri_done,
                   want.status);
          $display("  got  byte %02h comp %0d has %0b done %0b st %0d",
                   got.byte_out, got.component, got.has_byte, got.uri_done, got.status);
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte_in = 8'd0;
  logic       in_end_of_uri = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_out;
  logic [2:0] out_component;
  logic       out_has_byte;
  logic       out_uri_done;
  logic [2:0] out_status;

  // stimulus stream, built up front, sent with bursts and gaps
  logic [7:0] stim_byte[$];
  logic       stim_end[$];
  int         uri_count = 0;

  splitter_scoreboard sb;

  uri_component_splitter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte_in   (in_byte_in),
    .in_end_of_uri(in_end_of_uri),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_out (out_byte_out),
    .out_component(out_component),
    .out_has_byte (out_has_byte),
    .out_uri_done (out_uri_done),
    .out_status   (out_status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------

  task automatic add_char(logic [7:0] b);
    stim_byte.push_back(b);
    stim_end.push_back(1'b0);
  endtask

  // closes the uri on the most recent character
  task automatic close_uri();
    stim_end[stim_end.size() - 1] = 1'b1;
    uri_count++;
  endtask

  task automatic add_literal(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    close_uri();
  endtask

  function automatic logic [7:0] letter_char();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(UC_A, UC_Z));
    return 8'($urandom_range(LC_A, LC_Z));
  endfunction

  function automatic logic [7:0] scheme_char();
    case ($urandom_range(0, 3))
      0, 1: return letter_char();
      2: return 8'($urandom_range(DIG_0, DIG_9));
      default: begin
        case ($urandom_range(0, 2))
          0: return CH_PLUS;
          1: return CH_MINUS;
          default: return CH_DOT;
        endcase
      end
    endcase
  endfunction

  // now and then a byte that is probably not a hex digit at all
  function automatic logic [7:0] hex_char();
    case ($urandom_range(0, 15))
      0: return 8'($urandom_range(0, 255));
      1, 2, 3, 4, 5: return 8'($urandom_range(DIG_0, DIG_9));
      6, 7, 8, 9, 10: return 8'($urandom_range(LC_A, LC_F));
      default: return 8'($urandom_range(UC_A, UC_F));
    endcase
  endfunction

  // mostly plain text, with separators and raw bytes mixed in
  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return scheme_char();
      5: return CH_SLASH;
      6: return CH_COLON;
      7: return ($urandom_range(0, 1) == 0) ? CH_QMARK : CH_HASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_escape();
    add_char(CH_PCT);
    add_char(hex_char());
    add_char(hex_char());
  endtask

  task automatic add_text(int n);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) add_escape();
      else add_char(text_char());
    end
  endtask

  // mostly well-formed uris with random content, some noise, some cut short
  task automatic add_random_uri();
    int first;
    int cut;
    first = stim_byte.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 11) == 0) add_escape();
        else add_char(scheme_char());
      end
      if ($urandom_range(0, 19) == 0) add_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 11) != 0) begin
        add_char(CH_COLON);
        case ($urandom_range(0, 3))
          0: begin
            add_char(CH_SLASH);
            add_char(CH_SLASH);
            add_text($urandom_range(0, 4));
          end
          1: add_char(CH_SLASH);
          default: ;
        endcase
        // drive letter candidate
        if ($urandom_range(0, 2) == 0) begin
          add_char(CH_SLASH);
          add_char(($urandom_range(0, 4) == 0) ? text_char() : letter_char());
          if ($urandom_range(0, 4) != 0) add_char(CH_COLON);
        end
        add_text($urandom_range(0, 5));
        if ($urandom_range(0, 2) == 0) begin
          add_char(CH_QMARK);
          add_text($urandom_range(0, 4));
        end
        if ($urandom_range(0, 3) == 0) begin
          add_char(CH_HASH);
          add_text($urandom_range(0, 4));
        end
      end
    end
    if (stim_byte.size() == first) add_char(scheme_char());
    // end the uri early, anywhere, so every state sees an end flag
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(first + 1, stim_byte.size());
      while (stim_byte.size() > cut) begin
        void'(stim_byte.pop_back());
        void'(stim_end.pop_back());
      end
    end
    close_uri();
  endtask

  task automatic build_stimulus();
    // drive letter after "scheme:/", lower case raised
    add_literal("A+9:/c:");
    // authority with an escape, path opened, uri ends mid escape
    add_literal("0://%4a/%");
    // bad scheme byte, remainder discarded
    add_char(8'hff);
    add_char(8'h71);
    close_uri();
    // bad hex digit on the final byte
    add_literal("%g");
    // bad scheme byte that is itself the final byte
    add_char(8'h00);
    close_uri();
    // decoded escape in the scheme goes unchecked, uri ends in the scheme
    add_literal("%7E");
    // query and fragment straight after the colon
    add_literal("b:?#");
    while (stim_byte.size() < 28 + RANDOM_ITEMS) add_random_uri();
  endtask

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // sender: bursts of random length, random gaps, occasional long runs
  task automatic send_stream();
    int idx;
    int burst;
    int gap;
    idx = 0;
    while (idx < stim_byte.size()) begin
      burst = $urandom_range(1, 20);
      if ($urandom_range(0, 7) == 0) burst = $urandom_range(40, 120);
      while (burst > 0 && idx < stim_byte.size()) begin
        in_valid <= 1'b1;
        in_byte_in <= stim_byte[idx];
        in_end_of_uri <= stim_end[idx];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        burst--;
      end
      if (idx < stim_byte.size()) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
  endtask

  // receiver: switches between free running, light, heavy and periodic stalls
  initial begin : stall_pattern
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 200);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((k % 8) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: both handshakes sampled at the edge that completes them
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    res_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_byte_in, in_end_of_uri);
      if (out_valid === 1'b1 && !out_stall) begin
        got.byte_out = out_byte_out;
        got.component = out_component;
        got.has_byte = out_has_byte;
        got.uri_done = out_uri_done;
        got.status = out_status;
        sb.check_result(got);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed", CYCLE_LIMIT, sb.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------

  initial begin
    sb = new();
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_stream();
    // let the owed results drain, then a few more cycles for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d characters in %0d uris, checked %0d results (%0d error statuses)",
             stim_byte.size(), uri_count, sb.checked, sb.error_statuses);
    $display("%0d failures, %0d results left owed", sb.failures, sb.pending());
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
